[sv/fault_degradation_tracker_unit_macros.svh]
// ----------------------------------------------------------------------------
// Fault degradation tracker assertion macros
// Shared concurrent assertion forms for the tracker's checks.
// ----------------------------------------------------------------------------
`ifndef FAULT_DEGRADATION_TRACKER_UNIT_MACROS_SVH
`define FAULT_DEGRADATION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Tracker check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Tracker check failed.");

`endif

[sv/fdt_pkg.sv]
// ----------------------------------------------------------------------------
// Fault degradation tracker package
// Shared constants, codes, control structs and the degradation lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdt_pkg;

  localparam int MAX_SLOTS_DEF = 8;
  localparam int FAULT_KINDS   = 9;

  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic [2:0] LEVEL_EMERGENCY = 3'd4;

  localparam logic [2:0] DEGRADE_TABLE [FAULT_KINDS][5] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4},
    '{3'd2, 3'd3, 3'd3, 3'd3, 3'd4},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4},
    '{3'd3, 3'd4, 3'd4, 3'd4, 3'd4}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_MAX,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic walk_clr;
    logic walk_step;
    logic rec_match;
    logic do_update;
    logic max_step;
    logic commit_max;
    logic load_result;
  } fdt_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic match;
    logic id_valid;
    logic is_report;
    logic is_clear;
    logic found;
    logic full;
  } fdt_stat_t;

  function automatic logic [2:0] degrade_lookup(input logic [3:0] id, input logic [2:0] lvl);
    logic [2:0] col;
    logic [2:0] res;
    col = (lvl > 3'd4) ? 3'd4 : lvl;
    res = 3'd0;
    if (id < 4'(FAULT_KINDS)) begin
      res = DEGRADE_TABLE[id][col];
    end
    return res;
  endfunction

endpackage

[sv/fdt_ctrl.sv]
// ----------------------------------------------------------------------------
// Fault degradation tracker controller
// Sequences the slot search, the slot update, the level walk and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  fdt_pkg::fdt_stat_t stat_i,
  output fdt_pkg::fdt_cmd_t  cmd_o
);
  import fdt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!stat_i.id_valid) begin
          state_d = ST_RESULT;
        end else if (stat_i.walk_done || stat_i.match) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (stat_i.is_clear || (stat_i.is_report && (stat_i.found || !stat_i.full))) begin
          state_d = ST_MAX;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_MAX: begin
        if (stat_i.walk_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
        cmd_o.walk_clr  = in_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.rec_match = stat_i.id_valid && !stat_i.walk_done && stat_i.match;
        cmd_o.walk_step = stat_i.id_valid && !stat_i.walk_done && !stat_i.match;
      end
      ST_UPDATE: begin
        cmd_o.do_update = 1'b1;
        cmd_o.walk_clr  = 1'b1;
      end
      ST_MAX: begin
        cmd_o.max_step   = !stat_i.walk_done;
        cmd_o.commit_max = stat_i.walk_done;
      end
      ST_RESULT: begin
        cmd_o.load_result = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/fdt_datapath.sv]
// ----------------------------------------------------------------------------
// Fault degradation tracker datapath
// Slot table, walk counter, level accumulator and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdt_datapath #(
  parameter int MaxSlots = fdt_pkg::MAX_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         fault_id_i,
  input  fdt_pkg::fdt_cmd_t  cmd_i,
  output fdt_pkg::fdt_stat_t stat_o,
  output logic [2:0]         degrade_level_o,
  output logic               fault_active_o,
  output logic [3:0]         active_count_o,
  output logic [1:0]         status_o
);
  import fdt_pkg::*;

  localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int CntW = $clog2(MaxSlots + 1);

  logic [3:0]      slot_fault_q  [MaxSlots];
  logic            slot_active_q [MaxSlots];
  logic [2:0]      slot_level_q  [MaxSlots];
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] act_cnt_q;
  logic [2:0]      overall_q;
  logic [CntW-1:0] walk_q;
  logic [2:0]      acc_q;
  logic [1:0]      mode_q;
  logic [3:0]      id_q;
  logic            found_q;
  logic [IdxW-1:0] idx_q;
  logic            found_act_q;
  logic [2:0]      found_lvl_q;
  logic            drop_q;

  logic [2:0]      level_res_q;
  logic            active_res_q;
  logic [3:0]      count_res_q;
  logic [1:0]      status_res_q;

  logic [IdxW-1:0] walk_idx;
  logic [IdxW-1:0] slot_sel;
  logic            id_valid;
  logic            is_report;
  logic            is_clear;
  logic            full;
  logic [2:0]      table_lvl;
  logic [2:0]      new_lvl;
  logic [2:0]      walk_lvl;
  logic [CntW+3:0] cnt_ext;

  assign walk_idx  = walk_q[IdxW-1:0];
  assign id_valid  = id_q < 4'(FAULT_KINDS);
  assign is_report = mode_q == MODE_REPORT;
  assign is_clear  = mode_q == MODE_CLEAR;
  assign full      = used_q == CntW'(MaxSlots);
  assign slot_sel  = found_q ? idx_q : used_q[IdxW-1:0];
  assign table_lvl = degrade_lookup(id_q, overall_q);
  assign new_lvl   = (found_q && (found_lvl_q > table_lvl)) ? found_lvl_q : table_lvl;
  assign walk_lvl  = slot_active_q[walk_idx] ? slot_level_q[walk_idx] : 3'd0;
  assign cnt_ext   = {4'd0, act_cnt_q};

  assign stat_o.walk_done = walk_q == used_q;
  assign stat_o.match     = slot_fault_q[walk_idx] == id_q;
  assign stat_o.id_valid  = id_valid;
  assign stat_o.is_report = is_report;
  assign stat_o.is_clear  = is_clear;
  assign stat_o.found     = found_q;
  assign stat_o.full      = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSlots; i++) begin
        slot_fault_q[i]  <= '0;
        slot_active_q[i] <= 1'b0;
        slot_level_q[i]  <= '0;
      end
      used_q      <= '0;
      act_cnt_q   <= '0;
      overall_q   <= '0;
      walk_q      <= '0;
      acc_q       <= '0;
      mode_q      <= '0;
      id_q        <= '0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      found_act_q <= 1'b0;
      found_lvl_q <= '0;
      drop_q      <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        mode_q      <= mode_i;
        id_q        <= fault_id_i;
        found_q     <= 1'b0;
        found_act_q <= 1'b0;
        drop_q      <= 1'b0;
      end
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
        acc_q  <= '0;
      end
      if (cmd_i.walk_step) begin
        walk_q <= walk_q + CntW'(1);
      end
      if (cmd_i.max_step) begin
        walk_q <= walk_q + CntW'(1);
        if (walk_lvl > acc_q) begin
          acc_q <= walk_lvl;
        end
      end
      if (cmd_i.commit_max) begin
        overall_q <= acc_q;
      end
      if (cmd_i.rec_match) begin
        found_q     <= 1'b1;
        idx_q       <= walk_idx;
        found_act_q <= slot_active_q[walk_idx];
        found_lvl_q <= slot_level_q[walk_idx];
      end
      if (cmd_i.do_update) begin
        if (is_report) begin
          if (found_q || !full) begin
            slot_fault_q[slot_sel]  <= id_q;
            slot_active_q[slot_sel] <= 1'b1;
            slot_level_q[slot_sel]  <= new_lvl;
            if (!(found_q && found_act_q)) begin
              act_cnt_q <= act_cnt_q + CntW'(1);
            end
            if (!found_q) begin
              used_q <= used_q + CntW'(1);
            end
            found_q     <= 1'b1;
            idx_q       <= slot_sel;
            found_act_q <= 1'b1;
          end else begin
            drop_q <= 1'b1;
          end
        end else if (is_clear && found_q) begin
          slot_active_q[idx_q] <= 1'b0;
          slot_level_q[idx_q]  <= 3'd0;
          if (found_act_q) begin
            act_cnt_q <= act_cnt_q - CntW'(1);
          end
          found_act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      level_res_q  <= (!id_valid && (is_report || is_clear)) ? LEVEL_EMERGENCY : overall_q;
      active_res_q <= id_valid && found_q && found_act_q;
      count_res_q  <= cnt_ext[3:0];
      status_res_q <= !id_valid ? STATUS_INVALID : (drop_q ? STATUS_FULL : STATUS_OK);
    end
  end

  assign degrade_level_o = level_res_q;
  assign fault_active_o  = active_res_q;
  assign active_count_o  = count_res_q;
  assign status_o        = status_res_q;

endmodule

[sv/fault_degradation_tracker_unit.sv]
// Operation: a report or clear runs the slot search walk and then the level walk; a
// query, or a report dropped on a full table, runs only the slot search walk, and a
// request with an invalid fault id runs neither. Each walk visits one table slot per
// cycle. A new request is accepted only after the result of the current one is loaded.
// Reset: asynchronous, active low; clears the slot table, counts and system level.
`timescale 1ns / 1ps
`include "fault_degradation_tracker_unit_macros.svh"

// ----------------------------------------------------------------------------
// Fault degradation tracker
// Tracks fault reports in a slot table and derives the system degradation level.
// ----------------------------------------------------------------------------
module fault_degradation_tracker_unit #(
  parameter int MAX_SLOTS = fdt_pkg::MAX_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] fault_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] degrade_level_o,
  output logic       fault_active_o,
  output logic [3:0] active_count_o,
  output logic [1:0] status_o
);
  import fdt_pkg::*;

  fdt_cmd_t  cmd;
  fdt_stat_t stat;

  fdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fdt_datapath #(
    .MaxSlots (MAX_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .fault_id_i      (fault_id_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .degrade_level_o (degrade_level_o),
    .fault_active_o  (fault_active_o),
    .active_count_o  (active_count_o),
    .status_o        (status_o)
  );

  `FDT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `FDT_ASSERT_IMPL(a_invalid_not_active, clk_i, rst_ni, out_valid_o && (status_o == STATUS_INVALID), !fault_active_o)
  `FDT_ASSERT_IMPL(a_full_not_active, clk_i, rst_ni, out_valid_o && (status_o == STATUS_FULL), !fault_active_o)

endmodule
